### rtl/core/stereo_slew_soft_clipper_core_assert.svh
// Assertion macros shared by the checker of the stereo slew soft clipper core.
`ifndef STEREO_SLEW_SOFT_CLIPPER_CORE_ASSERT_SVH
`define STEREO_SLEW_SOFT_CLIPPER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SSC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/core/ssc_pkg.sv
// Types, constants and command codes shared by the soft clipper modules.
package ssc_pkg;

   // Sample format: signed, four integer bits (Q3.20 at 24 bits).
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC        = SAMPLE_BITS - 4;
   localparam int CSHIFT      = 28 - FRAC;

   // Delay line depth and the width of an index into it.
   localparam int MAX_SPACING = 16;
   localparam int IDX_W       = (MAX_SPACING > 1) ? $clog2(MAX_SPACING) : 1;
   localparam int SPC_W       = 5;

   typedef logic signed [SAMPLE_BITS-1:0]   sample_type;
   typedef logic signed [SAMPLE_BITS+1:0]   wide_type;
   typedef logic signed [2*SAMPLE_BITS-1:0] product_type;
   typedef logic        [IDX_W-1:0]         index_type;
   typedef logic        [SPC_W-1:0]         spacing_type;

   // Coefficients held with 28 fraction bits.
   localparam longint Q28_HARD = 165902236;
   localparam longint Q28_SOFT = 102533220;
   localparam longint Q28_REFC = 434337692;

   // Round a Q.28 constant to nearest into the sample fraction.
   function automatic longint from_q28(input longint c);
      longint r;
      if (CSHIFT <= 0) begin
         r = c;
      end else begin
         r = (c + (longint'(1) <<< (CSHIFT - 1))) >>> CSHIFT;
      end
      return r;
   endfunction

   localparam sample_type ONE      = sample_type'(longint'(1) <<< FRAC);
   localparam sample_type NEG_ONE  = sample_type'(-(longint'(1) <<< FRAC));
   localparam sample_type HARD     = sample_type'(from_q28(Q28_HARD));
   localparam sample_type NEG_HARD = sample_type'(-from_q28(Q28_HARD));
   localparam sample_type SOFT     = sample_type'(from_q28(Q28_SOFT));
   localparam sample_type REFC     = sample_type'(from_q28(Q28_REFC));
   localparam sample_type NEG_REFC = sample_type'(-from_q28(Q28_REFC));
   localparam wide_type   FOUR     = wide_type'(longint'(4) <<< FRAC);
   localparam wide_type   NEG_FOUR = wide_type'(-(longint'(4) <<< FRAC));

   // Half an output LSB, added to a product before the shift.
   localparam product_type ROUND_HALF = product_type'(longint'(1) <<< (FRAC - 1));

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_POS,
      ST_UPD_POS,
      ST_MUL_PX,
      ST_UPD_PX,
      ST_MUL_NEG,
      ST_UPD_NEG,
      ST_MUL_NX,
      ST_UPD_NX,
      ST_COMMIT
   } ctrl_state_type;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_POS,
      OP_UPD_POS,
      OP_MUL_PX,
      OP_UPD_PX,
      OP_MUL_NEG,
      OP_UPD_NEG,
      OP_MUL_NX,
      OP_UPD_NX,
      OP_COMMIT
   } dp_op_type;

   // Command from the controller to both channel datapaths.
   typedef struct packed {
      dp_op_type op;
   } cmd_type;

endpackage

### rtl/core/stereo_slew_soft_clipper_core.sv
// The sequencer runs four multiply-and-update steps through the one multiplier
// of each channel and takes a new request only after the last one is committed.
// A finished result waits in the output register while the next request runs.
// Reset is synchronous: it clears the delay lines, the overshoot flags and the
// handshake state, and sets the spacing register to 1.
module stereo_slew_soft_clipper_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ssc_pkg::sample_type req_left_sample,
   input  ssc_pkg::sample_type req_right_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ssc_pkg::sample_type rsp_left_result,
   output ssc_pkg::sample_type rsp_right_result,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  ssc_pkg::spacing_type csr_spacing
);

   ssc_pkg::spacing_type spacing_ff, spacing_in;
   ssc_pkg::index_type   last_idx;
   ssc_pkg::cmd_type     cmd;

   // Spacing register, always writable.
   assign csr_ready = 1'b1;

   always_comb begin
      spacing_in = spacing_ff;
      if (csr_valid) begin
         spacing_in = csr_spacing;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= ssc_pkg::spacing_type'(1);
      end else begin
         spacing_ff <= spacing_in;
      end
   end

   // Tail position of the delay line; zero acts as one, large values saturate.
   always_comb begin
      if (spacing_ff == '0) begin
         last_idx = '0;
      end else if (int'(spacing_ff) > ssc_pkg::MAX_SPACING) begin
         last_idx = ssc_pkg::index_type'(ssc_pkg::MAX_SPACING - 1);
      end else begin
         last_idx = ssc_pkg::index_type'(spacing_ff - ssc_pkg::spacing_type'(1));
      end
   end

   ssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   ssc_chan u_left (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sample   (req_left_sample),
      .last_idx (last_idx),
      .result   (rsp_left_result)
   );

   ssc_chan u_right (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sample   (req_right_sample),
      .last_idx (last_idx),
      .result   (rsp_right_result)
   );

endmodule

### rtl/core/ssc_ctrl.sv
// Sequencer that steps both channel datapaths through one request.
module ssc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssc_pkg::cmd_type cmd
);

   ssc_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_free;
   logic                    commit_go;

   // The output register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = ssc_pkg::ST_MUL_POS;
            end
         end
         ssc_pkg::ST_MUL_POS: state_in = ssc_pkg::ST_UPD_POS;
         ssc_pkg::ST_UPD_POS: state_in = ssc_pkg::ST_MUL_PX;
         ssc_pkg::ST_MUL_PX:  state_in = ssc_pkg::ST_UPD_PX;
         ssc_pkg::ST_UPD_PX:  state_in = ssc_pkg::ST_MUL_NEG;
         ssc_pkg::ST_MUL_NEG: state_in = ssc_pkg::ST_UPD_NEG;
         ssc_pkg::ST_UPD_NEG: state_in = ssc_pkg::ST_MUL_NX;
         ssc_pkg::ST_MUL_NX:  state_in = ssc_pkg::ST_UPD_NX;
         ssc_pkg::ST_UPD_NX:  state_in = ssc_pkg::ST_COMMIT;
         ssc_pkg::ST_COMMIT: begin
            if (out_free) begin
               state_in = ssc_pkg::ST_IDLE;
            end
         end
         default: state_in = ssc_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshake and datapath command.
   always_comb begin
      req_ready = 1'b0;
      commit_go = 1'b0;
      cmd.op    = ssc_pkg::OP_NONE;
      unique case (state_ff)
         ssc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = ssc_pkg::OP_LOAD;
            end
         end
         ssc_pkg::ST_MUL_POS: cmd.op = ssc_pkg::OP_MUL_POS;
         ssc_pkg::ST_UPD_POS: cmd.op = ssc_pkg::OP_UPD_POS;
         ssc_pkg::ST_MUL_PX:  cmd.op = ssc_pkg::OP_MUL_PX;
         ssc_pkg::ST_UPD_PX:  cmd.op = ssc_pkg::OP_UPD_PX;
         ssc_pkg::ST_MUL_NEG: cmd.op = ssc_pkg::OP_MUL_NEG;
         ssc_pkg::ST_UPD_NEG: cmd.op = ssc_pkg::OP_UPD_NEG;
         ssc_pkg::ST_MUL_NX:  cmd.op = ssc_pkg::OP_MUL_NX;
         ssc_pkg::ST_UPD_NX:  cmd.op = ssc_pkg::OP_UPD_NX;
         ssc_pkg::ST_COMMIT: begin
            if (out_free) begin
               commit_go = 1'b1;
               cmd.op    = ssc_pkg::OP_COMMIT;
            end
         end
         default: cmd.op = ssc_pkg::OP_NONE;
      endcase
   end

   // Result valid flag: set on commit, cleared when the result is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/core/ssc_chan.sv
// Datapath of one channel: clamp, slew limit, soft clip and delay line.
module ssc_chan (
   input  logic                clock,
   input  logic                reset,
   input  ssc_pkg::cmd_type    cmd,
   input  ssc_pkg::sample_type sample,
   input  ssc_pkg::index_type  last_idx,
   output ssc_pkg::sample_type result
);

   ssc_pkg::sample_type  x_ff, x_in;
   ssc_pkg::sample_type  last_ff, last_in;
   ssc_pkg::product_type prod_ff, prod_in;
   ssc_pkg::sample_type  result_ff, result_in;
   logic                 pos_over_ff, pos_over_in;
   logic                 neg_over_ff, neg_over_in;
   ssc_pkg::sample_type  line_ff [ssc_pkg::MAX_SPACING];
   ssc_pkg::sample_type  line_in [ssc_pkg::MAX_SPACING];

   ssc_pkg::sample_type  prev;
   ssc_pkg::wide_type    in_wide;
   ssc_pkg::wide_type    clamped;
   ssc_pkg::wide_type    prev_wide;
   ssc_pkg::wide_type    diff;
   ssc_pkg::wide_type    slewed;
   ssc_pkg::sample_type  mul_a, mul_b;
   ssc_pkg::product_type rnd_full;
   ssc_pkg::sample_type  rnd;

   // The previous sample is always the head of the delay line, the oldest one held.
   assign prev   = line_ff[0];
   assign result = result_ff;

   // Clamp to plus or minus four, then limit the step against the previous sample.
   always_comb begin
      in_wide   = ssc_pkg::wide_type'(sample);
      prev_wide = ssc_pkg::wide_type'(prev);
      if (in_wide > ssc_pkg::FOUR) begin
         clamped = ssc_pkg::FOUR;
      end else if (in_wide < ssc_pkg::NEG_FOUR) begin
         clamped = ssc_pkg::NEG_FOUR;
      end else begin
         clamped = in_wide;
      end
      diff = clamped - prev_wide;
      if (diff > ssc_pkg::wide_type'(ssc_pkg::HARD)) begin
         slewed = prev_wide + ssc_pkg::wide_type'(ssc_pkg::HARD);
      end else if (diff < ssc_pkg::wide_type'(ssc_pkg::NEG_HARD)) begin
         slewed = prev_wide + ssc_pkg::wide_type'(ssc_pkg::NEG_HARD);
      end else begin
         slewed = clamped;
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = ssc_pkg::sample_type'(last_ff);
      mul_b = ssc_pkg::SOFT;
      case (cmd.op)
         ssc_pkg::OP_MUL_POS: begin
            if (x_ff < last_ff) begin
               mul_a = x_ff;
               mul_b = ssc_pkg::SOFT;
            end else begin
               mul_a = last_ff;
               mul_b = ssc_pkg::HARD;
            end
         end
         ssc_pkg::OP_MUL_NEG: begin
            if (x_ff > last_ff) begin
               mul_a = x_ff;
               mul_b = ssc_pkg::SOFT;
            end else begin
               mul_a = last_ff;
               mul_b = ssc_pkg::HARD;
            end
         end
         default: begin
            mul_a = last_ff;
            mul_b = ssc_pkg::SOFT;
         end
      endcase
      prod_in = ssc_pkg::product_type'(mul_a) * ssc_pkg::product_type'(mul_b);
   end

   // Registered product rounded to nearest, ties upward.
   always_comb begin
      rnd_full = (prod_ff + ssc_pkg::ROUND_HALF) >>> ssc_pkg::FRAC;
      rnd      = ssc_pkg::sample_type'(rnd_full);
   end

   // Per-operation state updates.
   always_comb begin
      x_in        = x_ff;
      last_in     = last_ff;
      pos_over_in = pos_over_ff;
      neg_over_in = neg_over_ff;
      result_in   = result_ff;
      line_in     = line_ff;
      unique case (cmd.op)
         ssc_pkg::OP_NONE: begin
            x_in = x_ff;
         end
         ssc_pkg::OP_LOAD: begin
            x_in    = ssc_pkg::sample_type'(slewed);
            last_in = prev;
         end
         ssc_pkg::OP_MUL_POS, ssc_pkg::OP_MUL_PX,
         ssc_pkg::OP_MUL_NEG, ssc_pkg::OP_MUL_NX: begin
            x_in = x_ff;
         end
         ssc_pkg::OP_UPD_POS: begin
            if (pos_over_ff) begin
               last_in = ((x_ff < last_ff) ? ssc_pkg::ONE : ssc_pkg::HARD) + rnd;
            end
         end
         ssc_pkg::OP_UPD_PX: begin
            pos_over_in = (x_ff > ssc_pkg::REFC);
            if (x_ff > ssc_pkg::REFC) begin
               x_in = ssc_pkg::ONE + rnd;
            end
         end
         ssc_pkg::OP_UPD_NEG: begin
            if (neg_over_ff) begin
               last_in = ((x_ff > last_ff) ? ssc_pkg::NEG_ONE : ssc_pkg::NEG_HARD) + rnd;
            end
         end
         ssc_pkg::OP_UPD_NX: begin
            neg_over_in = (x_ff < ssc_pkg::NEG_REFC);
            if (x_ff < ssc_pkg::NEG_REFC) begin
               x_in = ssc_pkg::NEG_ONE + rnd;
            end
         end
         ssc_pkg::OP_COMMIT: begin
            // Shift the used part of the line and put the new sample at its tail.
            for (int k = 0; k < ssc_pkg::MAX_SPACING - 1; k++) begin
               if (ssc_pkg::index_type'(k) < last_idx) begin
                  line_in[k] = line_ff[k+1];
               end
            end
            line_in[last_idx] = x_ff;
            result_in         = last_ff;
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   // State that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_over_ff <= 1'b0;
         neg_over_ff <= 1'b0;
         line_ff     <= '{default: '0};
      end else begin
         pos_over_ff <= pos_over_in;
         neg_over_ff <= neg_over_in;
         line_ff     <= line_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      last_ff   <= last_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

endmodule

### rtl/core/ssc_checker.sv
// Port-level checker for the soft clipper core and its bind to the top level.
`include "stereo_slew_soft_clipper_core_assert.svh"

module ssc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ssc_pkg::sample_type  rsp_left_result,
   input ssc_pkg::sample_type  rsp_right_result,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   // A stalled result stays valid and unchanged.
   `SSC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_left_result) && $stable(rsp_right_result))

   // Only one request is in work at a time.
   `SSC_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

   // Every accepted request has a result waiting once its steps are through.
   `SSC_ASSERT_IMPL(a_result_due, req_valid && req_ready, ##10 rsp_valid)

   // The spacing register never stalls a write.
   `SSC_ASSERT_IMPL(a_csr_open, csr_valid, csr_ready)

endmodule

bind stereo_slew_soft_clipper_core ssc_checker u_checker (.*);
